// ----- sv/stbr_pkg.sv -----
// ----------------------------------------------------------------------------
// Stick to body rate acceleration: shared types and constants
// Pipeline depths, angle constants, series divisors and the bundles that
// travel between the datapath modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stbr_pkg;

  // divider: one quotient bit per stage
  localparam int DIVIDEND_W = 40;
  localparam int DIVISOR_W  = 24;
  localparam int DIV_LAT    = DIVIDEND_W;

  // sine unit: wrap, fold, square, three stages per series term, two to finish
  localparam int TAY_TERMS = 4;
  localparam int SC_LAT    = 5 + 3 * TAY_TERMS;

  // control law tail
  localparam int LAW_LAT = 5;
  localparam int SUM_W   = 44;

  localparam logic signed [17:0] Q13_PI      = 18'sd25736;
  localparam logic signed [17:0] Q13_TWO_PI  = 18'sd51472;
  localparam logic signed [17:0] Q13_HALF_PI = 18'sd12868;

  localparam logic [30:0] T_ONE = 31'h4000_0000;

  // series divisors 72, 42, 20, 6 split into a shift and a small odd factor
  localparam int unsigned TAY_SH  [TAY_TERMS] = '{3, 1, 2, 1};
  localparam int unsigned TAY_DIV [TAY_TERMS] = '{9, 21, 5, 3};
  localparam logic [30:0] TAY_RCP [TAY_TERMS] = '{
    31'((64'd1 << 32) / 64'd9),
    31'((64'd1 << 32) / 64'd21),
    31'((64'd1 << 32) / 64'd5),
    31'((64'd1 << 32) / 64'd3)
  };

  typedef enum logic [7:0] {
    CFG_DYN_PRESSURE = 8'd0,
    CFG_ELEV_GAIN    = 8'd1,
    CFG_AIL_GAIN     = 8'd2,
    CFG_RUD_GAIN     = 8'd3,
    CFG_PITCH_HOLD   = 8'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        [23:0] design_dyn_pressure;
    logic        [15:0] elevator_gain;
    logic        [15:0] aileron_gain;
    logic        [15:0] rudder_gain;
    logic signed [15:0] pitch_hold_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] stick_pitch;
    logic signed [15:0] stick_roll;
    logic signed [15:0] stick_yaw;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] cos_alpha;
    logic signed [15:0] cos_phi;
    logic signed [15:0] sin_phi;
    logic signed [15:0] cos_theta;
  } trig_t;

  function automatic logic signed [31:0] sat_acc(input logic signed [SUM_W-1:0] x);
    logic signed [31:0] r;
    if (x > SUM_W'(32'sh7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SUM_W'(-33'sh8000_0000)) begin
      r = -32'sh8000_0000;
    end else begin
      r = 32'(x);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/stick_to_body_rate_accel_top.sv -----
// Throughput: one transaction per cycle while the output is not stalled; the
// 40-stage divider and the sine units are fully pipelined, and a stall on the
// output freezes every stage.
// Reset clears all stage valid bits and the output valid, and loads the
// default gains with a zero design pressure.
// ----------------------------------------------------------------------------
// Stick to body rate acceleration, top level
// Dynamic pressure, pipelined ratio division, sine/cosine units and the
// control law, with an output register and a configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_to_body_rate_accel_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               autopilot_on_i,
  input  logic [15:0]        airspeed_i,
  input  logic [16:0]        air_density_i,
  input  logic signed [15:0] attack_angle_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] stick_pitch_i,
  input  logic signed [15:0] stick_roll_i,
  input  logic signed [15:0] stick_yaw_i,
  input  logic signed [15:0] roll_rate_i,
  input  logic signed [15:0] pitch_rate_i,
  input  logic signed [15:0] yaw_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] roll_accel_o,
  output logic signed [31:0] pitch_accel_o,
  output logic signed [31:0] yaw_accel_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  localparam int PIPE_LAT = 2 + stbr_pkg::DIV_LAT + stbr_pkg::LAW_LAT;
  localparam int TRIG_DLY = 1 + stbr_pkg::DIV_LAT - stbr_pkg::SC_LAT;
  localparam int CMD_DLY  = 2 + stbr_pkg::DIV_LAT;

  logic adv;

  stbr_pkg::cfg_t cfg_q;

  logic [PIPE_LAT-1:0] vld_q;

  logic [31:0]        vsq_q;
  logic [16:0]        rho_q;
  logic signed [16:0] arg_ca_q, arg_cp_q, arg_sp_q, arg_ct_q;
  logic [48:0]        qraw;
  logic [stbr_pkg::DIVIDEND_W-1:0] dividend_q;
  logic [stbr_pkg::DIVIDEND_W-1:0] base;

  stbr_pkg::cmd_t  cmd_d;
  stbr_pkg::cmd_t  cmd_q  [CMD_DLY];
  stbr_pkg::trig_t trig_d;
  stbr_pkg::trig_t trig_q [TRIG_DLY];

  logic signed [15:0] cos_alpha, cos_phi, sin_phi, cos_theta;
  logic signed [stbr_pkg::SUM_W-1:0] roll_sum, pitch_sum, yaw_sum;

  logic               out_valid_q;
  logic signed [31:0] roll_q, pitch_q, yaw_q;

  // advance everything whenever the output register can take a new value
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.design_dyn_pressure <= '0;
      cfg_q.elevator_gain       <= 16'd5719;
      cfg_q.aileron_gain        <= 16'd14298;
      cfg_q.rudder_gain         <= 16'd5719;
      cfg_q.pitch_hold_gain     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        stbr_pkg::CFG_DYN_PRESSURE: cfg_q.design_dyn_pressure <= cfg_data_i;
        stbr_pkg::CFG_ELEV_GAIN:    cfg_q.elevator_gain       <= cfg_data_i[15:0];
        stbr_pkg::CFG_AIL_GAIN:     cfg_q.aileron_gain        <= cfg_data_i[15:0];
        stbr_pkg::CFG_RUD_GAIN:     cfg_q.rudder_gain         <= cfg_data_i[15:0];
        stbr_pkg::CFG_PITCH_HOLD:   cfg_q.pitch_hold_gain     <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // valid bits; an autopilot transaction enters as a bubble
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i && !autopilot_on_i};
    end
  end

  assign cmd_d = '{stick_pitch: stick_pitch_i, stick_roll: stick_roll_i,
                   stick_yaw: stick_yaw_i, roll_rate: roll_rate_i,
                   pitch_rate: pitch_rate_i, yaw_rate: yaw_rate_i};

  // dividing by 2^9 first leaves the floor of the quotient unchanged
  assign qraw = 49'(vsq_q) * 49'(rho_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vsq_q      <= 32'(airspeed_i) * 32'(airspeed_i);
      rho_q      <= air_density_i;
      arg_ca_q   <= 17'(attack_angle_i) + 17'(stbr_pkg::Q13_HALF_PI);
      arg_cp_q   <= 17'(roll_angle_i) + 17'(stbr_pkg::Q13_HALF_PI);
      arg_sp_q   <= 17'(roll_angle_i);
      arg_ct_q   <= 17'(pitch_angle_i) + 17'(stbr_pkg::Q13_HALF_PI);
      dividend_q <= qraw[48:9];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_q[0] <= cmd_d;
      for (int k = 1; k < CMD_DLY; k++) begin
        cmd_q[k] <= cmd_q[k-1];
      end
    end
  end

  stbr_div u_div (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (dividend_q),
    .divisor_i  (cfg_q.design_dyn_pressure),
    .quotient_o (base)
  );

  stbr_sincos u_cos_alpha (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (arg_ca_q),
    .value_o (cos_alpha)
  );

  stbr_sincos u_cos_phi (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (arg_cp_q),
    .value_o (cos_phi)
  );

  stbr_sincos u_sin_phi (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (arg_sp_q),
    .value_o (sin_phi)
  );

  stbr_sincos u_cos_theta (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (arg_ct_q),
    .value_o (cos_theta)
  );

  assign trig_d = '{cos_alpha: cos_alpha, cos_phi: cos_phi,
                    sin_phi: sin_phi, cos_theta: cos_theta};

  // align the trig values with the divider output
  always_ff @(posedge clk_i) begin
    if (adv) begin
      trig_q[0] <= trig_d;
      for (int k = 1; k < TRIG_DLY; k++) begin
        trig_q[k] <= trig_q[k-1];
      end
    end
  end

  stbr_law u_law (
    .clk_i       (clk_i),
    .en_i        (adv),
    .cfg_i       (cfg_q),
    .base_i      (base),
    .trig_i      (trig_q[TRIG_DLY-1]),
    .cmd_i       (cmd_q[CMD_DLY-1]),
    .roll_sum_o  (roll_sum),
    .pitch_sum_o (pitch_sum),
    .yaw_sum_o   (yaw_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q  <= stbr_pkg::sat_acc(roll_sum);
      pitch_q <= stbr_pkg::sat_acc(pitch_sum);
      yaw_q   <= stbr_pkg::sat_acc(yaw_sum);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_accel_o  = roll_q;
  assign pitch_accel_o = pitch_q;
  assign yaw_accel_o   = yaw_q;

`ifndef SYNTH
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !autopilot_on_i) |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_autopilot_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && autopilot_on_i) |=> !vld_q[0])
    else $error("autopilot transaction produced a valid stage");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output is stalled");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while frozen");
`endif

endmodule

`default_nettype wire

// ----- sv/stbr_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stbr_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [stbr_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [stbr_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic [stbr_pkg::DIVIDEND_W-1:0] quotient_o
);

  localparam int NW = stbr_pkg::DIVIDEND_W;
  localparam int DW = stbr_pkg::DIVISOR_W;

  logic [DW-1:0] rem_q  [stbr_pkg::DIV_LAT];
  logic [NW-1:0] work_q [stbr_pkg::DIV_LAT];

  for (genvar i = 0; i < stbr_pkg::DIV_LAT; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] work_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = dividend_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign work_in = work_q[i-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_in, work_in[NW-1]};
    assign diff  = trial - {1'b0, divisor_i};
    assign ge    = (trial >= {1'b0, divisor_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        work_q[i] <= {work_in[NW-2:0], ge};
      end
    end
  end

  assign quotient_o = work_q[stbr_pkg::DIV_LAT-1];

endmodule

`default_nettype wire

// ----- sv/stbr_sincos.sv -----
// ----------------------------------------------------------------------------
// Pipelined sine unit
// Wraps and folds a Q3.13 angle, evaluates the odd series to the ninth power
// in Q.30 and rounds to Q1.14. Cosine callers add a quarter turn up front.
// ----------------------------------------------------------------------------
`default_nettype none

module stbr_sincos (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [16:0] angle_i,
  output logic signed [15:0] value_o
);

  typedef struct packed {
    logic        neg;
    logic [13:0] mag;
    logic [31:0] sq;
  } carry_t;

  localparam int NT = stbr_pkg::TAY_TERMS;

  logic signed [17:0] wrap_d, wrap_q;
  logic signed [17:0] fold;
  logic [13:0]        mag_d, mag_q;
  logic               neg_d, neg_q;
  logic [31:0]        sq_d;
  carry_t             head_q;

  carry_t      cm_q [NT];
  carry_t      cr_q [NT];
  carry_t      cc_q [NT];
  logic [31:0] p_q  [NT];
  logic [30:0] y_q  [NT];
  logic [61:0] pr_q [NT];
  logic [30:0] t_q  [NT];

  logic [44:0] fin_prod;
  logic [31:0] sraw_q;
  logic        sneg_q;
  logic [16:0] rnd;
  logic [14:0] mag_s;
  logic signed [15:0] value_d, value_q;

  // wrap into [-pi, pi]
  always_comb begin
    wrap_d = 18'(angle_i);
    if (wrap_d > stbr_pkg::Q13_PI) begin
      wrap_d = wrap_d - stbr_pkg::Q13_TWO_PI;
    end
    if (wrap_d < -stbr_pkg::Q13_PI) begin
      wrap_d = wrap_d + stbr_pkg::Q13_TWO_PI;
    end
  end

  // fold into [-pi/2, pi/2] and split off the sign
  always_comb begin
    fold = wrap_q;
    if (fold > stbr_pkg::Q13_HALF_PI) begin
      fold = stbr_pkg::Q13_PI - fold;
    end
    if (fold < -stbr_pkg::Q13_HALF_PI) begin
      fold = -stbr_pkg::Q13_PI - fold;
    end
    neg_d = fold[17];
    mag_d = neg_d ? 14'(-fold) : 14'(fold);
  end

  // x is mag << 17, so (x * x) >> 30 is exactly mag^2 << 4
  assign sq_d = (32'(mag_q) * 32'(mag_q)) << 4;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wrap_q     <= wrap_d;
      mag_q      <= mag_d;
      neg_q      <= neg_d;
      head_q.neg <= neg_q;
      head_q.mag <= mag_q;
      head_q.sq  <= sq_d;
    end
  end

  for (genvar k = 0; k < NT; k++) begin : g_term
    logic [30:0] t_cur;
    carry_t      c_cur;
    logic [61:0] prod;
    logic [30:0] y_d;
    logic [29:0] q0;
    logic [30:0] rem;
    logic [29:0] q;

    if (k == 0) begin : g_first
      assign t_cur = stbr_pkg::T_ONE;
      assign c_cur = head_q;
    end else begin : g_next
      assign t_cur = t_q[k-1];
      assign c_cur = cc_q[k-1];
    end

    assign prod = 62'(c_cur.sq) * 62'(t_cur);
    assign y_d  = 31'(p_q[k] >> stbr_pkg::TAY_SH[k]);

    // reciprocal estimate is low by at most one, fix it with one compare
    assign q0  = pr_q[k][61:32];
    assign rem = y_q[k] - 31'(q0) * 31'(stbr_pkg::TAY_DIV[k]);
    assign q   = q0 + 30'(rem >= 31'(stbr_pkg::TAY_DIV[k]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cm_q[k] <= c_cur;
        p_q[k]  <= prod[61:30];
        cr_q[k] <= cm_q[k];
        y_q[k]  <= y_d;
        pr_q[k] <= 62'(y_d) * 62'(stbr_pkg::TAY_RCP[k]);
        cc_q[k] <= cr_q[k];
        t_q[k]  <= stbr_pkg::T_ONE - 31'(q);
      end
    end
  end

  assign fin_prod = 45'(cc_q[NT-1].mag) * 45'(t_q[NT-1]);

  // round half up to Q1.14 and clamp at one
  always_comb begin
    rnd = 17'((sraw_q + 32'd32768) >> 16);
    if (rnd > 17'd16384) begin
      rnd = 17'd16384;
    end
    mag_s   = rnd[14:0];
    value_d = sneg_q ? (16'sd0 - $signed({1'b0, mag_s})) : $signed({1'b0, mag_s});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sraw_q  <= fin_prod[44:13];
      sneg_q  <= cc_q[NT-1].neg;
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ----- sv/stbr_law.sv -----
// ----------------------------------------------------------------------------
// Control law tail
// Ratio from quotient and cos(alpha), stick and pitch moment terms, minus the
// body rates. Five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module stbr_law (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  stbr_pkg::cfg_t                        cfg_i,
  input  logic [stbr_pkg::DIVIDEND_W-1:0]       base_i,
  input  stbr_pkg::trig_t                       trig_i,
  input  stbr_pkg::cmd_t                        cmd_i,
  output logic signed [stbr_pkg::SUM_W-1:0]     roll_sum_o,
  output logic signed [stbr_pkg::SUM_W-1:0]     pitch_sum_o,
  output logic signed [stbr_pkg::SUM_W-1:0]     yaw_sum_o
);

  localparam int SW = stbr_pkg::SUM_W;

  stbr_pkg::trig_t tr1_q, tr2_q;
  stbr_pkg::cmd_t  cm1_q, cm2_q, cm3_q, cm4_q;

  // stage 1
  logic signed [56:0] pa_d, pa_q;
  // stage 2
  logic signed [42:0] pa_sh;
  logic signed [31:0] ratio_d, ratio_q;
  // stage 3
  logic signed [33:0] dif;
  logic signed [32:0] sgp_d, sgr_d, sgy_d, sgp_q, sgr_q, sgy_q;
  logic signed [49:0] md_d, md_q;
  logic signed [31:0] ccp_d, csp_d, ccp_q, csp_q;
  logic signed [31:0] rt3_q;
  // stage 4
  logic signed [64:0] stp_d, str_d, sty_d, stp_q, str_q, sty_q;
  logic signed [37:0] mval;
  logic signed [17:0] ccv, csv;
  logic signed [55:0] mc_d, ms_d, mc_q, ms_q;
  // stage 5
  logic signed [SW-1:0] roll_d, pitch_d, yaw_d, roll_q, pitch_q, yaw_q;

  assign pa_d = 57'($signed({1'b0, base_i})) * 57'(trig_i.cos_alpha);

  // floor shift, clamp, and no ratio at all without a design pressure
  always_comb begin
    pa_sh = $signed(pa_q[56:14]);
    if (cfg_i.design_dyn_pressure == '0) begin
      ratio_d = '0;
    end else if (pa_sh > 43'sd2147483647) begin
      ratio_d = 32'sd2147483647;
    end else if (pa_sh < -43'sd2147483647) begin
      ratio_d = -32'sd2147483647;
    end else begin
      ratio_d = 32'(pa_sh);
    end
  end

  assign sgp_d = 33'(cm2_q.stick_pitch) * 33'($signed({1'b0, cfg_i.elevator_gain}));
  assign sgr_d = 33'(cm2_q.stick_roll) * 33'($signed({1'b0, cfg_i.aileron_gain}));
  assign sgy_d = 33'(cm2_q.stick_yaw) * 33'($signed({1'b0, cfg_i.rudder_gain}));
  assign dif   = 34'sd65536 - 34'(ratio_q);
  assign md_d  = 50'(dif) * 50'(cfg_i.pitch_hold_gain);
  assign ccp_d = 32'(tr2_q.cos_theta) * 32'(tr2_q.cos_phi);
  assign csp_d = 32'(tr2_q.cos_theta) * 32'(tr2_q.sin_phi);

  assign stp_d = 65'(sgp_q) * 65'(rt3_q);
  assign str_d = 65'(sgr_q) * 65'(rt3_q);
  assign sty_d = 65'(sgy_q) * 65'(rt3_q);
  assign mval  = $signed(md_q[49:12]);
  assign ccv   = $signed(ccp_q[31:14]);
  assign csv   = $signed(csp_q[31:14]);
  assign mc_d  = 56'(mval) * 56'(ccv);
  assign ms_d  = 56'(mval) * 56'(csv);

  assign roll_d  = SW'($signed(str_q[64:29]))
                 - SW'($signed({cm4_q.roll_rate, 5'b00000}));
  assign pitch_d = SW'($signed(stp_q[64:29])) + SW'($signed(mc_q[55:14]))
                 - SW'($signed({cm4_q.pitch_rate, 5'b00000}));
  assign yaw_d   = SW'($signed(sty_q[64:29])) - SW'($signed(ms_q[55:14]))
                 - SW'($signed({cm4_q.yaw_rate, 5'b00000}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q    <= pa_d;
      tr1_q   <= trig_i;
      cm1_q   <= cmd_i;
      ratio_q <= ratio_d;
      tr2_q   <= tr1_q;
      cm2_q   <= cm1_q;
      sgp_q   <= sgp_d;
      sgr_q   <= sgr_d;
      sgy_q   <= sgy_d;
      md_q    <= md_d;
      ccp_q   <= ccp_d;
      csp_q   <= csp_d;
      rt3_q   <= ratio_q;
      cm3_q   <= cm2_q;
      stp_q   <= stp_d;
      str_q   <= str_d;
      sty_q   <= sty_d;
      mc_q    <= mc_d;
      ms_q    <= ms_d;
      cm4_q   <= cm3_q;
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

  assign roll_sum_o  = roll_q;
  assign pitch_sum_o = pitch_q;
  assign yaw_sum_o   = yaw_q;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Stick to body rate acceleration: self-checking testbench
// Drives sample sets and register writes into the block. A local fixed-point
// model predicts the three accelerations. Each output transaction is checked
// in order against the oldest prediction, with random idle and stall bursts
// on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CFG_IDX_UNUSED = 8'd5;
  localparam int         DRAIN_CYCLES   = 60;
  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         LONG_HOLD      = 200;
  localparam int         Q13_PI_I       = 25736;
  localparam int         Q13_HPI_I      = 12868;
  localparam longint     RATIO_MAX      = 64'sd2147483647;

  typedef struct {
    bit              autopilot;
    bit [15:0]       airspeed;
    bit [16:0]       density;
    bit signed [15:0] alpha, phi, theta;
    bit signed [15:0] sp, sr, sy;
    bit signed [15:0] p, q, r;
  } sample_t;

  typedef struct {
    bit signed [31:0] roll, pitch, yaw;
  } accel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic autopilot_on_i = 1'b0;
  logic [15:0] airspeed_i = '0;
  logic [16:0] air_density_i = '0;
  logic signed [15:0] attack_angle_i = '0, roll_angle_i = '0, pitch_angle_i = '0;
  logic signed [15:0] stick_pitch_i = '0, stick_roll_i = '0, stick_yaw_i = '0;
  logic signed [15:0] roll_rate_i = '0, pitch_rate_i = '0, yaw_rate_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] roll_accel_o, pitch_accel_o, yaw_accel_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  // local copy of the register file
  bit [23:0]        m_ddp;
  bit [15:0]        m_elev, m_ail, m_rud;
  bit signed [15:0] m_phg;

  accel_t accel_q[$];
  int     errors = 0;
  bit     idle_en = 1'b1;
  bit     long_hold_req = 1'b0;
  int     cycles = 0;

  stick_to_body_rate_accel_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int sin_q14(int a);
    bit neg = 0;
    longint unsigned x, x2, t, s;
    if (a > Q13_PI_I) a -= 2 * Q13_PI_I;
    if (a < -Q13_PI_I) a += 2 * Q13_PI_I;
    if (a > Q13_HPI_I) a = Q13_PI_I - a;
    if (a < -Q13_HPI_I) a = -Q13_PI_I - a;
    if (a < 0) begin
      neg = 1;
      a = -a;
    end
    x  = longint'(a) << 17;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + (64'd1 << 15)) >> 16;
    if (s > 16384) s = 16384;
    return neg ? -int'(s) : int'(s);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic accel_t predict_accel(sample_t s);
    accel_t res;
    longint unsigned qraw, base;
    longint ratio, m, cc, cs, cth, cphi, sphi, roll, pitch, yaw;
    ratio = 0;
    qraw  = longint'(s.airspeed) * longint'(s.airspeed) * longint'(s.density);
    if (m_ddp != 0) begin
      base  = qraw / (longint'(m_ddp) << 9);
      ratio = (longint'(base) * sin_q14(int'(s.alpha) + Q13_HPI_I)) >>> 14;
      if (ratio > RATIO_MAX) ratio = RATIO_MAX;
      if (ratio < -RATIO_MAX) ratio = -RATIO_MAX;
    end
    cphi  = sin_q14(int'(s.phi) + Q13_HPI_I);
    sphi  = sin_q14(int'(s.phi));
    cth   = sin_q14(int'(s.theta) + Q13_HPI_I);
    m     = ((65536 - ratio) * longint'(m_phg)) >>> 12;
    cc    = (cth * cphi) >>> 14;
    cs    = (cth * sphi) >>> 14;
    roll  = ((longint'(s.sr) * longint'(m_ail) * ratio) >>> 29) - longint'(s.p) * 32;
    pitch = ((longint'(s.sp) * longint'(m_elev) * ratio) >>> 29)
          + ((m * cc) >>> 14) - longint'(s.q) * 32;
    yaw   = ((longint'(s.sy) * longint'(m_rud) * ratio) >>> 29)
          - ((m * cs) >>> 14) - longint'(s.r) * 32;
    res.roll  = 32'(sat32(roll));
    res.pitch = 32'(sat32(pitch));
    res.yaw   = 32'(sat32(yaw));
    return res;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.autopilot = ($urandom_range(7) == 0);
    s.airspeed  = 16'($urandom());
    s.density   = 17'($urandom());
    s.alpha     = 16'($urandom());
    s.phi       = 16'($urandom());
    s.theta     = 16'($urandom());
    s.sp        = 16'($urandom());
    s.sr        = 16'($urandom());
    s.sy        = 16'($urandom());
    s.p         = 16'($urandom());
    s.q         = 16'($urandom());
    s.r         = 16'($urandom());
    return s;
  endfunction

  function automatic sample_t flat_sample(bit ap, bit [15:0] v, bit [16:0] rho,
                                          bit signed [15:0] ang, bit signed [15:0] val);
    sample_t s;
    s.autopilot = ap;
    s.airspeed  = v;
    s.density   = rho;
    s.alpha     = ang;
    s.phi       = ang;
    s.theta     = ang;
    s.sp        = val;
    s.sr        = val;
    s.sy        = val;
    s.p         = val;
    s.q         = val;
    s.r         = val;
    return s;
  endfunction

  // Offer one sample set and hold it until the block takes it.
  task automatic send_sample(sample_t s);
    if (idle_en && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    autopilot_on_i <= s.autopilot;
    airspeed_i     <= s.airspeed;
    air_density_i  <= s.density;
    attack_angle_i <= s.alpha;
    roll_angle_i   <= s.phi;
    pitch_angle_i  <= s.theta;
    stick_pitch_i  <= s.sp;
    stick_roll_i   <= s.sr;
    stick_yaw_i    <= s.sy;
    roll_rate_i    <= s.p;
    pitch_rate_i   <= s.q;
    yaw_rate_i     <= s.r;
    do @(posedge clk_i); while (in_stall_o);
    if (!s.autopilot) accel_q.push_back(predict_accel(s));
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every predicted result has arrived, then let the pipe empty.
  task automatic wait_drained();
    while (accel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      stbr_pkg::CFG_DYN_PRESSURE: m_ddp  = data;
      stbr_pkg::CFG_ELEV_GAIN:    m_elev = data[15:0];
      stbr_pkg::CFG_AIL_GAIN:     m_ail  = data[15:0];
      stbr_pkg::CFG_RUD_GAIN:     m_rud  = data[15:0];
      stbr_pkg::CFG_PITCH_HOLD:   m_phg  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [23:0] ddp, logic [15:0] elev, logic [15:0] ail,
                          logic [15:0] rud, logic [15:0] phg);
    drop_valid();
    wait_drained();
    write_reg(stbr_pkg::CFG_DYN_PRESSURE, ddp);
    write_reg(stbr_pkg::CFG_ELEV_GAIN, {8'h00, elev});
    write_reg(stbr_pkg::CFG_AIL_GAIN, {8'h00, ail});
    write_reg(stbr_pkg::CFG_RUD_GAIN, {8'h00, rud});
    write_reg(stbr_pkg::CFG_PITCH_HOLD, {8'hA5, phg});
  endtask

  task automatic test_defaults();
    // zero design pressure leaves only the moment and rate terms
    send_sample(flat_sample(1'b0, 16'hFFFF, 17'h1FFFF, 16'sh7FFF, 16'sh7FFF));
    send_sample(flat_sample(1'b0, 16'h0000, 17'h00000, -16'sh8000, -16'sh8000));
    send_sample(flat_sample(1'b1, 16'h1234, 17'h0ABCD, 16'sd0, 16'sd0));
    send_sample(flat_sample(1'b0, 16'h4000, 17'h10000, 16'sd0, 16'sd100));
  endtask

  task automatic test_directed();
    // tiny design pressure drives the ratio into its clamp
    set_regs(24'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
    send_sample(flat_sample(1'b0, 16'hFFFF, 17'h1FFFF, 16'sd0, 16'sh7FFF));
    send_sample(flat_sample(1'b0, 16'hFFFF, 17'h1FFFF, 16'sd25736, -16'sh8000));
    send_sample(flat_sample(1'b0, 16'hFFFF, 17'h1FFFF, -16'sd25736, 16'sh7FFF));
    send_sample(flat_sample(1'b0, 16'h0001, 17'h00001, 16'sd12868, 16'sd1));
    send_sample(flat_sample(1'b1, 16'hFFFF, 17'h1FFFF, 16'sd0, 16'sh7FFF));
    // largest design pressure and zero stick gains
    set_regs(24'hFFFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    send_sample(flat_sample(1'b0, 16'hFFFF, 17'h1FFFF, 16'sh7FFF, 16'sh7FFF));
    send_sample(flat_sample(1'b0, 16'hFFFF, 17'h1FFFF, -16'sh8000, -16'sh8000));
    send_sample(flat_sample(1'b0, 16'h8000, 17'h10000, -16'sd12868, 16'sd0));
    // an unknown register index changes nothing
    drop_valid();
    wait_drained();
    write_reg(CFG_IDX_UNUSED, 24'hFFFFFF);
    send_sample(flat_sample(1'b0, 16'h7FFF, 17'h0FFFF, 16'sd6434, -16'sd1));
    send_sample(flat_sample(1'b0, 16'h00FF, 17'h1FFFF, 16'sd19302, 16'sd2048));
  endtask

  task automatic test_random(int n);
    repeat (n) send_sample(rand_sample());
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    test_random(80);
    long_hold_req = 1'b0;
    drop_valid();
    wait_drained();
  endtask

  // stall driver: short random bursts, or one long hold on request
  int hold_left = 0;
  int burst_left = 0;
  always @(posedge clk_i) begin
    if (long_hold_req && hold_left == 0 && burst_left >= 0) begin
      hold_left  <= LONG_HOLD;
      burst_left <= -1;
      out_stall_i <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left == 1) begin
      hold_left <= 0;
      out_stall_i <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (idle_en && burst_left == 0 && $urandom_range(4) == 0) begin
        burst_left <= $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        if (!long_hold_req) burst_left <= 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    accel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (accel_q.size() == 0) begin
        $display("%0t: unexpected transaction roll %0d pitch %0d yaw %0d",
                 $time, roll_accel_o, pitch_accel_o, yaw_accel_o);
        errors++;
      end else begin
        want = accel_q.pop_front();
        if (roll_accel_o !== want.roll) begin
          $display("%0t: roll_accel expected %0d actual %0d", $time, want.roll, roll_accel_o);
          errors++;
        end
        if (pitch_accel_o !== want.pitch) begin
          $display("%0t: pitch_accel expected %0d actual %0d", $time, want.pitch, pitch_accel_o);
          errors++;
        end
        if (yaw_accel_o !== want.yaw) begin
          $display("%0t: yaw_accel expected %0d actual %0d", $time, want.yaw, yaw_accel_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    m_ddp  = 24'd0;
    m_elev = 16'd5719;
    m_ail  = 16'd14298;
    m_rud  = 16'd5719;
    m_phg  = 16'sd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_random(40);
    test_directed();
    set_regs(24'd4096, 16'd5719, 16'd14298, 16'd5719, 16'h1000);
    test_random(100);
    test_backpressure();
    set_regs(24'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
             16'($urandom()));
    test_random(100);
    set_regs(24'd300, 16'd16384, 16'd8192, 16'd30000, 16'hE000);
    test_random(60);
    idle_en = 1'b0;
    test_random(60);
    drop_valid();
    wait_drained();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
